// File: sv/mld_pkg.sv
// shared types and constants for the mosaic line drawer
package mld_pkg;

	localparam int COLS = 40;
	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] RECIP_3 = 8'd86;

	localparam logic [1:0] OP_LINE  = 2'd0;
	localparam logic [1:0] OP_PUT   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// store command from controller to datapath
	typedef struct packed {
		logic load;       // capture item and set up line
		logic step_rd;    // issue read of current pixel cell
		logic step_wr;    // write modified cell, advance line
		logic put_wr;     // write character
		logic get_rd;     // read byte
		logic clr_wr;     // write one byte of the clear sweep
		logic clr_start;  // zero the sweep address
	} mld_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic line_done;  // the last pixel has been handled
		logic clr_done;   // sweep is at last address
		logic addr_bad;   // put or read address off screen
	} mld_sts_t;

	// odd parity in bit 7
	function automatic logic [7:0] with_parity(input logic [6:0] v);
		with_parity = {~(^v), v};
	endfunction

	// graphics colour codes
	function automatic logic [7:0] gfx_code(input logic [2:0] c);
		case (c)
			3'd0: gfx_code = 8'h10;
			3'd1: gfx_code = 8'h94;
			3'd2: gfx_code = 8'h91;
			3'd3: gfx_code = 8'h15;
			3'd4: gfx_code = 8'h92;
			3'd5: gfx_code = 8'h16;
			3'd6: gfx_code = 8'h13;
			default: gfx_code = 8'h97;
		endcase
	endfunction

	// mosaic bit for a sub row and x parity
	function automatic logic [6:0] cell_bit(input logic [1:0] sub, input logic xo);
		case ({sub, xo})
			3'b000: cell_bit = 7'd33;
			3'b001: cell_bit = 7'd34;
			3'b010: cell_bit = 7'd36;
			3'b011: cell_bit = 7'd40;
			3'b100: cell_bit = 7'd48;
			3'b101: cell_bit = 7'd96;
			default: cell_bit = 7'd0;
		endcase
	endfunction

endpackage

// File: sv/mosaic_line_drawer.sv
// top level of the mosaic line drawer: controller, datapath, output register
// Usage: one item enters on s_axis (operation and operands packed in
// s_axis_tdata), and exactly one result leaves on m_axis. Operations are
// draw line, put character, read byte and clear store.
// A line visits each pixel along its major axis, up to 128 pixels. The
// store has a single port: each line pixel is a read and then a write of
// one byte, and a clear writes one byte per cycle over TEXT_ROWS*40 bytes.
// One item is handled at a time; s_axis_tready is high only when idle.
// Reset: after arst_n releases, a clearing pass writes spaces to all
// TEXT_ROWS*40 bytes before the first item is taken.
// Stall: the result waits in the output register while m_axis_tready is low;
// the next item can be accepted and worked on meanwhile, and its result
// waits until the register empties.
module mosaic_line_drawer #(
	parameter int TEXT_ROWS = 24,
	parameter int PIXELS_X  = 78,
	parameter int PIXELS_Y  = 72
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// operation[1:0], x_start[8:2], y_start[15:9], x_end[22:16], y_end[29:23],
	// pixel_on[30], char_code[37:31], graphics_clear[38], color[41:39]
	input  logic [47:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// read_data[7:0], plotted_count[15:8], ignored[16]
	output logic [23:0] m_axis_tdata
);
	import mld_pkg::*;

	mld_cmd_t cmd;
	mld_sts_t sts;
	logic in_fire, res_valid, clearing, out_busy;
	logic [7:0] rd, pc;
	logic ign;
	logic [16:0] out_q;
	logic ovalid_q;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_busy = ovalid_q && !m_axis_tready;

	mld_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .op(s_axis_tdata[1:0]),
		.out_busy(out_busy), .sts(sts), .cmd(cmd), .in_ready(s_axis_tready),
		.res_valid(res_valid), .clearing(clearing)
	);

	mld_dp #(.TEXT_ROWS(TEXT_ROWS), .PIXELS_X(PIXELS_X), .PIXELS_Y(PIXELS_Y)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .clearing(clearing),
		.op(s_axis_tdata[1:0]), .x_start(s_axis_tdata[8:2]),
		.y_start(s_axis_tdata[15:9]), .x_end(s_axis_tdata[22:16]),
		.y_end(s_axis_tdata[29:23]), .pixel_on(s_axis_tdata[30]),
		.char_code(s_axis_tdata[37:31]), .graphics_clear(s_axis_tdata[38]),
		.color(s_axis_tdata[41:39]), .sts(sts), .read_data(rd),
		.plotted_count(pc), .ignored(ign)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_valid) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= {ign, pc, rd};
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {7'd0, out_q};

`ifndef SYNTHESIS
	// no item taken during the clearing pass
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready)
		else $error("item accepted while clearing");
	// a result never overwrites one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(ovalid_q && !m_axis_tready))
		else $error("result overwritten");
	// no pixel count beyond the longest line
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pc <= 8'd128)
		else $error("pixel count out of range");
`endif
endmodule

// File: sv/mld_ctrl.sv
// controller state machine for the mosaic line drawer
module mld_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic [1:0] op,
	input  logic out_busy,
	input  mld_pkg::mld_sts_t sts,
	output mld_pkg::mld_cmd_t cmd,
	output logic in_ready,
	output logic res_valid,
	output logic clearing
);
	import mld_pkg::*;

	localparam logic [3:0] S_RST_CLR = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_DISP    = 4'd2;
	localparam logic [3:0] S_LRD     = 4'd3;
	localparam logic [3:0] S_LWR     = 4'd4;
	localparam logic [3:0] S_GRD     = 4'd5;
	localparam logic [3:0] S_GWAIT   = 4'd6;
	localparam logic [3:0] S_CLR     = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] op_q;

	// item operation latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_LINE;
		end else if (in_fire) begin
			op_q <= op;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		cmd = '0;
		res_valid = 1'b0;
		unique case (state_q)
			S_RST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					cmd.clr_start = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (op_q)
					OP_LINE: state_d = S_LRD;
					OP_PUT: begin
						if (!sts.addr_bad) cmd.put_wr = 1'b1;
						state_d = S_DONE;
					end
					OP_READ: begin
						if (!sts.addr_bad) cmd.get_rd = 1'b1;
						state_d = S_GRD;
					end
					default: state_d = S_CLR;
				endcase
			end
			S_LRD: begin
				cmd.step_rd = 1'b1;
				state_d = S_LWR;
			end
			S_LWR: begin
				cmd.step_wr = 1'b1;
				state_d = sts.line_done ? S_DONE : S_LRD;
			end
			S_GRD: state_d = S_GWAIT;
			S_GWAIT: state_d = S_DONE;
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_busy) begin
					res_valid = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign clearing = (state_q == S_RST_CLR) || (state_q == S_CLR);
endmodule

// File: sv/mld_dp.sv
// datapath for the mosaic line drawer: store, line stepper, result values
module mld_dp #(
	parameter int TEXT_ROWS = 24,
	parameter int PIXELS_X  = 78,
	parameter int PIXELS_Y  = 72
) (
	input  logic clk,
	input  logic arst_n,
	input  mld_pkg::mld_cmd_t cmd,
	input  logic clearing,
	input  logic [1:0] op,
	input  logic [6:0] x_start,
	input  logic [6:0] y_start,
	input  logic [6:0] x_end,
	input  logic [6:0] y_end,
	input  logic pixel_on,
	input  logic [6:0] char_code,
	input  logic graphics_clear,
	input  logic [2:0] color,
	output mld_pkg::mld_sts_t sts,
	output logic [7:0] read_data,
	output logic [7:0] plotted_count,
	output logic ignored
);
	import mld_pkg::*;

	localparam int DEPTH = TEXT_ROWS * COLS;
	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// item fields
	logic [1:0] op_q;
	logic [6:0] xs_q, ys_q, ch_q;
	logic on_q, gfx_q;
	logic [2:0] color_q;

	// line walk state
	logic steep_q;
	logic signed [8:0] d_q, da_q, db_q;
	logic [6:0] p_q, pend_q;  // major axis
	logic [6:0] m_q;          // minor axis
	logic minc_q;
	logic [7:0] cnt_q;
	logic [AW-1:0] addr_q, clr_q;
	logic [5:0] clrcol_q;     // column of the clear sweep
	logic [6:0] bit_q;
	logic hit_q;

	// setup values
	logic [6:0] adx, ady, ax0, ay0, ax1, ay1;
	logic steep, swp;
	assign adx = (x_end > x_start) ? x_end - x_start : x_start - x_end;
	assign ady = (y_end > y_start) ? y_end - y_start : y_start - y_end;
	assign steep = !(ady < adx);
	assign swp = steep ? (y_start > y_end) : (x_start > x_end);
	assign ax0 = swp ? x_end : x_start;
	assign ay0 = swp ? y_end : y_start;
	assign ax1 = swp ? x_start : x_end;
	assign ay1 = swp ? y_start : y_end;

	// current pixel
	logic [6:0] px, py;
	logic [7:0] row;
	logic [14:0] prod;
	logic [1:0] sub;
	logic [6:0] col;
	logic onscr;
	logic [AW-1:0] paddr;
	assign px = steep_q ? m_q : p_q;
	assign py = steep_q ? p_q : m_q;
	assign prod = 15'(py) * 15'(RECIP_3);
	assign row = {1'b0, prod[14:8]};
	assign sub = 2'(py - 7'(row[6:0] * 7'd3));
	assign col = 7'(px[6:1]) + 7'd1;
	assign onscr = (32'(px) < PIXELS_X) && (32'(py) < PIXELS_Y) &&
		(32'(row) < TEXT_ROWS) && (32'(col) < COLS);
	assign paddr = AW'(32'(row) * COLS + 32'(col));

	// put or read address
	logic [AW-1:0] taddr;
	assign taddr = AW'(32'(ys_q) * COLS + 32'(xs_q));
	assign sts.addr_bad = (32'(xs_q) >= COLS) || (32'(ys_q) >= TEXT_ROWS);
	assign sts.line_done = (p_q == pend_q);
	assign sts.clr_done = (32'(clr_q) == DEPTH - 1);

	// clear sweep byte
	logic [7:0] clr_byte;
	always_comb begin
		clr_byte = (!clearing || !gfx_q || clrcol_q != '0) ? SPACE_CODE :
			gfx_code(color_q);
	end

	// modified cell
	logic [6:0] newc;
	assign newc = on_q ? (rdata_q[6:0] | bit_q) : (rdata_q[6:0] & ~bit_q);

	// store port: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_q] <= clr_byte;
		end else if (cmd.put_wr) begin
			mem[taddr] <= with_parity(ch_q);
		end else if (cmd.step_wr && hit_q) begin
			mem[addr_q] <= with_parity(newc);
		end
		if (cmd.step_rd) rdata_q <= mem[paddr];
		else if (cmd.get_rd) rdata_q <= mem[taddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clrcol_q <= '0;
			gfx_q <= 1'b0;
			op_q <= OP_LINE;
		end else begin
			if (cmd.clr_start) begin
				clr_q <= '0;
				clrcol_q <= '0;
			end else if (cmd.clr_wr && !sts.clr_done) begin
				clr_q <= clr_q + AW'(1);
				clrcol_q <= (clrcol_q == 6'(COLS - 1)) ? '0 : clrcol_q + 6'd1;
			end
			if (cmd.load) begin
				op_q <= op;
				gfx_q <= graphics_clear;
			end
		end
	end

	// item capture and line stepping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			xs_q <= x_start;
			ys_q <= y_start;
			ch_q <= char_code;
			on_q <= pixel_on;
			color_q <= color;
			steep_q <= steep;
			cnt_q <= '0;
			if (steep) begin
				p_q <= ay0; pend_q <= ay1; m_q <= ax0;
				minc_q <= (ax1 >= ax0);
				da_q <= 9'sd2 * $signed({2'b0, adx});
				db_q <= 9'sd2 * $signed({2'b0, ady});
				d_q <= 9'sd2 * $signed({2'b0, adx}) - $signed({2'b0, ady});
			end else begin
				p_q <= ax0; pend_q <= ax1; m_q <= ay0;
				minc_q <= (ay1 >= ay0);
				da_q <= 9'sd2 * $signed({2'b0, ady});
				db_q <= 9'sd2 * $signed({2'b0, adx});
				d_q <= 9'sd2 * $signed({2'b0, ady}) - $signed({2'b0, adx});
			end
		end
		if (cmd.step_rd) begin
			addr_q <= paddr;
			hit_q <= onscr;
			bit_q <= cell_bit(sub, px[0]);
		end
		if (cmd.step_wr) begin
			if (hit_q) cnt_q <= cnt_q + 8'd1;
			p_q <= p_q + 7'd1;
			if (d_q > 0) begin
				m_q <= minc_q ? m_q + 7'd1 : m_q - 7'd1;
				d_q <= d_q - db_q + da_q;
			end else begin
				d_q <= d_q + da_q;
			end
		end
	end

	// result values
	assign read_data = (op_q == OP_READ && !sts.addr_bad) ? rdata_q : 8'd0;
	assign plotted_count = (op_q == OP_LINE) ? cnt_q : 8'd0;
	assign ignored = (op_q == OP_PUT || op_q == OP_READ) && sts.addr_bad;
endmodule
